FILE: sv/sliding_window_average_defines.svh
// Assertion macros for the sliding window average block.
`ifndef SLIDING_WINDOW_AVERAGE_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define SWA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Check that a condition never holds outside reset.
`define SWA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define SWA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: sv/swa_pkg.sv
`default_nettype none

package swa_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Width of the window length register.
  localparam int unsigned CFG_BITS = 7;

  typedef logic [CFG_BITS-1:0] cfg_t;

  localparam cfg_t WINDOW_RESET = cfg_t'(1);
  localparam cfg_t COUNT_MAX    = cfg_t'(127);

endpackage

`default_nettype wire

FILE: sv/swa_if.sv
`default_nettype none

// Sample channel into the filter.
interface swa_in_if #(
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// Result channel out of the filter.
interface swa_out_if #(
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          averaged;

  modport source (output valid, output value, output averaged, input ready);
  modport sink   (input valid, input value, input averaged, output ready);
endinterface

// Window length write channel.
interface swa_cfg_if;
  logic         valid;
  logic         ready;
  swa_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/sliding_window_average.sv
// Simple moving average filter. Each signed sample on in_i gives one result on out_o: during
// the first W-1 samples of a sequence the sample itself with averaged low, from then on the
// sum of the last W samples divided by W (truncated toward zero, saturated to the sample
// range) with averaged high. A sample with last set closes the sequence and clears the count
// and the sum. W is written through cfg_i (0 acts as 1, values above MAX_WINDOW act as
// MAX_WINDOW) and takes effect with the next sample. The recent samples sit in a one-port-write,
// one-port-read memory of MAX_WINDOW entries with a registered read; it needs no clearing after
// reset. One sample at a time is in flight: a passthrough sample goes through accept and memory read,
// sum update and output load; an averaged sample also passes through the restoring divider,
// which retires one quotient bit per cycle, between the sum update and the output load.
// The next sample is taken while a result still waits on out_o.
`default_nettype none

module sliding_window_average #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  swa_in_if.sink    in_i,
  swa_out_if.source out_o,
  swa_cfg_if.sink   cfg_i
);

`include "sliding_window_average_defines.svh"

  localparam int unsigned CFG_BITS  = swa_pkg::CFG_BITS;
  localparam int unsigned SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + SLOT_BITS;
  localparam int unsigned IDX_BITS  = ((SLOT_BITS > CFG_BITS) ? SLOT_BITS : CFG_BITS) + 1;
  localparam int unsigned REM_BITS  = CFG_BITS + 1;
  localparam int unsigned CNT_BITS  = $clog2(SUM_BITS + 1);
  localparam int unsigned CLAMP_W   = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;

  localparam logic [SUM_BITS-1:0] POS_LIM =
    {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0] NEG_LIM =
    {{(SUM_BITS-SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                 state_q, state_d;
  swa_pkg::cfg_t              window_q;
  logic [SLOT_BITS-1:0]       ws_q, ws_d;
  swa_pkg::cfg_t              fill_q, fill_d;
  logic [SUM_BITS-1:0]        sum_q, sum_d;
  logic [SAMPLE_BITS-1:0]     s_q, s_d;
  logic                       last_q, last_d;
  logic                       avg_q, avg_d;
  logic                       self_q, self_d;
  swa_pkg::cfg_t              w_q, w_d;
  logic                       neg_q, neg_d;
  logic [SUM_BITS-1:0]        quo_q, quo_d;
  logic [REM_BITS-1:0]        rem_q, rem_d;
  logic [CNT_BITS-1:0]        cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]     value_q, value_d;
  logic                       averaged_q, averaged_d;

  logic [SAMPLE_BITS-1:0]     mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]     rdata_q;

  logic                       in_xfer;
  logic                       out_free;
  swa_pkg::cfg_t              w_eff;
  swa_pkg::cfg_t              wm1;
  logic [IDX_BITS-1:0]        ws_x, wm1_x;
  logic [IDX_BITS-1:0]        old_idx;
  logic [SLOT_BITS-1:0]       raddr;
  logic [SAMPLE_BITS-1:0]     old_s;
  logic [SUM_BITS-1:0]        mag;
  logic [REM_BITS-1:0]        rem_sh;
  logic                       q_bit;
  logic [SAMPLE_BITS-1:0]     sat_val;

  assign in_i.ready     = (state_q == S_IDLE);
  assign in_xfer        = in_i.valid && in_i.ready;
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.value    = value_q;
  assign out_o.averaged = averaged_q;
  assign out_free       = !out_valid_q || out_o.ready;

  // Effective window: zero acts as one, clamp to the store depth.
  always_comb begin
    w_eff = window_q;
    if (window_q == '0) begin
      w_eff = swa_pkg::cfg_t'(1);
    end else if (window_q > CLAMP_W[CFG_BITS-1:0]) begin
      w_eff = CLAMP_W[CFG_BITS-1:0];
    end
  end
  assign wm1 = w_eff - swa_pkg::cfg_t'(1);

  // Slot of the sample leaving the window, W-1 behind the one being written.
  assign ws_x    = IDX_BITS'(ws_q);
  assign wm1_x   = IDX_BITS'(wm1);
  assign old_idx = (ws_x >= wm1_x) ? (ws_x - wm1_x)
                                   : (ws_x + IDX_BITS'(MAX_WINDOW) - wm1_x);
  assign raddr   = old_idx[SLOT_BITS-1:0];

  // With a window of one the leaving sample is the one just taken.
  assign old_s = self_q ? s_q : rdata_q;
  assign mag   = sum_q[SUM_BITS-1] ? (~sum_q + SUM_BITS'(1)) : sum_q;

  assign rem_sh = {rem_q[CFG_BITS-1:0], quo_q[SUM_BITS-1]};
  assign q_bit  = (rem_sh >= {1'b0, w_q});

  always_comb begin
    if (!neg_q) begin
      sat_val = (quo_q > POS_LIM) ? VAL_MAX : quo_q[SAMPLE_BITS-1:0];
    end else begin
      sat_val = (quo_q > NEG_LIM) ? VAL_MIN : (~quo_q[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1));
    end
  end

  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    s_d         = s_q;
    last_d      = last_q;
    avg_d       = avg_q;
    self_d      = self_q;
    w_d         = w_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    averaged_d  = averaged_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          s_d    = in_i.sample;
          last_d = in_i.last;
          w_d    = w_eff;
          self_d = (w_eff == swa_pkg::cfg_t'(1));
          avg_d  = !(fill_q < wm1);
          sum_d  = sum_q + {{(SUM_BITS-SAMPLE_BITS){in_i.sample[SAMPLE_BITS-1]}},
                            in_i.sample};
          ws_d   = (ws_q == SLOT_BITS'(MAX_WINDOW - 1)) ? '0 : ws_q + SLOT_BITS'(1);
          if (in_i.last) begin
            fill_d = '0;
          end else if (fill_q != swa_pkg::COUNT_MAX) begin
            fill_d = fill_q + swa_pkg::cfg_t'(1);
          end
          state_d = S_READ;
        end
      end
      S_READ: begin
        // Latch the dividend, then clear the sum after a last sample or drop the leaving sample from it once averaging.
        neg_d = sum_q[SUM_BITS-1];
        quo_d = mag;
        rem_d = '0;
        cnt_d = CNT_BITS'(SUM_BITS);
        if (last_q) begin
          sum_d = '0;
        end else if (avg_q) begin
          sum_d = sum_q - {{(SUM_BITS-SAMPLE_BITS){old_s[SAMPLE_BITS-1]}}, old_s};
        end
        state_d = avg_q ? S_DIV : S_OUT;
      end
      S_DIV: begin
        rem_d = q_bit ? (rem_sh - {1'b0, w_q}) : rem_sh;
        quo_d = {quo_q[SUM_BITS-2:0], q_bit};
        cnt_d = cnt_q - CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = avg_q ? sat_val : s_q;
          averaged_d  = avg_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= swa_pkg::WINDOW_RESET;
      ws_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        window_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    last_q     <= last_d;
    avg_q      <= avg_d;
    self_q     <= self_d;
    w_q        <= w_d;
    neg_q      <= neg_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    value_q    <= value_d;
    averaged_q <= averaged_d;
  end

  // Sample store: write the new sample, read the leaving one in the same cycle.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mem[ws_q] <= in_i.sample;
      rdata_q   <= mem[raddr];
    end
  end

  `SWA_ASSERT(a_accept_then_read, clk_i, rst_ni, in_xfer |=> state_q == S_READ, "accepted sample did not move to the read step")
  `SWA_ASSERT(a_div_only_avg, clk_i, rst_ni, state_q == S_DIV |-> avg_q && cnt_q != '0, "divider running for a passthrough sample or with an empty count")
  `SWA_ASSERT(a_rem_below_div, clk_i, rst_ni, state_q == S_DIV |-> rem_q < {1'b0, w_q}, "divider remainder not below the window")
  `SWA_ASSERT(a_last_clears, clk_i, rst_ni, in_xfer && in_i.last |-> ##2 sum_q == '0 && fill_q == '0, "last transfer did not clear the count and the sum")

endmodule

`default_nettype wire
